@@ src/ising_metropolis_flip_defines.svh @@
// assertion macros for the ising metropolis flip block
`ifndef ISING_METROPOLIS_FLIP_DEFINES_SVH
`define ISING_METROPOLIS_FLIP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define IMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imf property violated");

// next-cycle implication, sampled on clk, off during rst
`define IMF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imf property violated");

`endif

@@ src/imf_pkg.sv @@
`timescale 1ns / 1ps

package imf_pkg;

  // lattice side, power of two
  localparam int SIDE  = 64;
  localparam int ROW_W = $clog2(SIDE);
  localparam int SITES = SIDE * SIDE;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int RND_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int DE_W      = 5;
  localparam int E_W       = 32;
  localparam int SQ_W      = 40;
  localparam int MAG_W     = 14;

  localparam int IN_W        = 32;
  localparam int IN_ROW_LSB  = 0;
  localparam int IN_COL_LSB  = 6;
  localparam int IN_RND_LSB  = 12;

  localparam int OUT_W       = 96;
  localparam int OUT_ACC_LSB = 0;
  localparam int OUT_DE_LSB  = 1;
  localparam int OUT_E_LSB   = 6;
  localparam int OUT_SQ_LSB  = 38;
  localparam int OUT_MAG_LSB = 78;

  localparam logic [CFG_W-1:0] ONE_FACTOR = CFG_W'(65536);

  localparam logic OP_FLIP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic signed [DE_W-1:0] DE_M8 = DE_W'(-8);
  localparam logic signed [DE_W-1:0] DE_M4 = DE_W'(-4);
  localparam logic signed [DE_W-1:0] DE_P4 = DE_W'(4);
  localparam logic signed [DE_W-1:0] DE_P8 = DE_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DE_M8     = 3'd0,
    REG_DE_M4     = 3'd1,
    REG_DE_P4     = 3'd2,
    REG_DE_P8     = 3'd3,
    REG_SPIN_UP   = 3'd4,
    REG_SPIN_DOWN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                   load;
    logic signed [DE_W-1:0] de;
    logic                   spin_up;
    logic [RND_W-1:0]       rnd;
  } acc_ctl_t;

  typedef struct packed {
    logic                   clear;
    logic                   update;
    logic signed [DE_W-1:0] de;
    logic                   spin_up;
  } stats_ctl_t;

endpackage

@@ src/imf_ram.sv @@
`timescale 1ns / 1ps

module imf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/imf_accept.sv @@
`timescale 1ns / 1ps

module imf_accept (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [imf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [imf_pkg::CFG_W-1:0]      cfg_wdata,
  input  imf_pkg::acc_ctl_t              ctl,
  output logic                           accept
);

  import imf_pkg::*;

  logic [CFG_W-1:0]   f_m8, f_m4, f_p4, f_p8, f_up, f_dn;
  logic [CFG_W-1:0]   fe, fs, fe_q, fs_q;
  logic [2*CFG_W-1:0] product_q, thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_m8 <= ONE_FACTOR;
      f_m4 <= ONE_FACTOR;
      f_p4 <= ONE_FACTOR;
      f_p8 <= ONE_FACTOR;
      f_up <= ONE_FACTOR;
      f_dn <= ONE_FACTOR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DE_M8:     f_m8 <= cfg_wdata;
        REG_DE_M4:     f_m4 <= cfg_wdata;
        REG_DE_P4:     f_p4 <= cfg_wdata;
        REG_DE_P8:     f_p8 <= cfg_wdata;
        REG_SPIN_UP:   f_up <= cfg_wdata;
        REG_SPIN_DOWN: f_dn <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ctl.de)
      DE_M8:   fe = f_m8;
      DE_M4:   fe = f_m4;
      DE_P4:   fe = f_p4;
      DE_P8:   fe = f_p8;
      default: fe = ONE_FACTOR;
    endcase
    fs = ctl.spin_up ? f_up : f_dn;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fe_q <= fe;
      fs_q <= fs;
    end
    product_q <= fe_q * fs_q;
  end

  // random fraction aligned to the u16.32 product
  assign thresh = (2*CFG_W)'({ctl.rnd, FRAC_W'(0)});
  assign accept = thresh < product_q;

endmodule

@@ src/imf_stats.sv @@
`timescale 1ns / 1ps

module imf_stats (
  input  logic                             clk,
  input  logic                             rst,
  input  imf_pkg::stats_ctl_t              ctl,
  output logic signed [imf_pkg::E_W-1:0]   energy,
  output logic [imf_pkg::SQ_W-1:0]         sq_energy,
  output logic signed [imf_pkg::MAG_W-1:0] mag
);

  import imf_pkg::*;

  logic signed [E_W:0]  e_wide;
  logic [SQ_W:0]        sq_wide;
  logic [DE_W-2:0]      de_abs;
  logic [2*DE_W-3:0]    de_sq;
  logic signed [E_W-1:0] e_sat;
  logic [SQ_W-1:0]      sq_sat;

  assign e_wide = (E_W+1)'(energy) + (E_W+1)'(ctl.de);
  assign e_sat  = (e_wide[E_W] != e_wide[E_W-1])
                ? (e_wide[E_W] ? {1'b1, {(E_W-1){1'b0}}} : {1'b0, {(E_W-1){1'b1}}})
                : e_wide[E_W-1:0];

  assign de_abs  = ctl.de[DE_W-1] ? (DE_W-1)'(-ctl.de) : ctl.de[DE_W-2:0];
  assign de_sq   = de_abs * de_abs;
  assign sq_wide = {1'b0, sq_energy} + (SQ_W+1)'(de_sq);
  assign sq_sat  = sq_wide[SQ_W] ? {SQ_W{1'b1}} : sq_wide[SQ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      energy    <= '0;
      sq_energy <= '0;
      mag       <= MAG_W'(SITES);
    end else if (ctl.update) begin
      energy    <= e_sat;
      sq_energy <= sq_sat;
      mag       <= ctl.spin_up ? mag - MAG_W'(2) : mag + MAG_W'(2);
    end
  end

endmodule

@@ src/ising_metropolis_flip.sv @@
// a flip request runs the lattice row read sequence (NBR, EVAL), the registered
//   factor multiply (MUL), the row write-back (DEC) and the output load (PUSH);
//   no new request is taken until PUSH has loaded the result for output
// a clear request sweeps the lattice memory one row per cycle, then passes PUSH
// reset: synchronous; the same clearing pass runs after reset, no request
//   is taken meanwhile; factors reset to 1.0, sums to 0, magnetization to 4096
`timescale 1ns / 1ps

module ising_metropolis_flip (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row_index[5:0], col_index[11:6], random_fraction[27:12], zero pad
  input  logic [imf_pkg::IN_W-1:0]        in_tdata,
  // op
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // accepted[0], delta_energy[5:1], energy_sum[37:6], sq_energy_sum[77:38],
  // magnetization[91:78], zero pad
  output logic [imf_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_we,
  input  logic [imf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [imf_pkg::CFG_W-1:0]       cfg_wdata
);

  import imf_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_NBR   = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DEC   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [ROW_W-1:0] clr_addr, row_q, col_q, row_in, col_in;
  logic [ROW_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [RND_W-1:0] rnd_q;
  logic [SIDE-1:0]  rd_data_a, rd_data_b, wr_data, row_word_q;
  logic             wr_en;
  logic             clr_push, north_q, south_q, spin_q, acc_q, accept;
  logic             in_req, op_clear, out_load;
  logic             s_bit, w_bit, e_bit;
  logic [2:0]       ups;
  logic signed [DE_W-1:0] de_q, de_up, de_eval;

  acc_ctl_t   acc_ctl;
  stats_ctl_t st_ctl;
  logic signed [E_W-1:0]   st_energy;
  logic [SQ_W-1:0]         st_sq;
  logic signed [MAG_W-1:0] st_mag;

  assign in_tready = (state == S_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign op_clear  = (in_tuser == OP_CLEAR);
  assign row_in    = in_tdata[IN_ROW_LSB +: ROW_W];
  assign col_in    = in_tdata[IN_COL_LSB +: ROW_W];
  assign out_load  = (state == S_PUSH) && (!out_tvalid || out_tready);

  // lattice rows: north and south read first, own row next
  assign rd_addr_a = (state == S_IDLE) ? row_in - 1'b1 : row_q;
  assign rd_addr_b = row_in + 1'b1;
  assign wr_en     = (state == S_CLEAR) || ((state == S_DEC) && accept);
  assign wr_addr   = (state == S_CLEAR) ? clr_addr : row_q;
  assign wr_data   = (state == S_CLEAR) ? {SIDE{1'b1}}
                                        : row_word_q ^ (SIDE'(1) << col_q);

  imf_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_lattice (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_data_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_data_b)
  );

  // energy change from the count of up neighbours
  assign s_bit   = rd_data_a[col_q];
  assign w_bit   = rd_data_a[col_q - 1'b1];
  assign e_bit   = rd_data_a[col_q + 1'b1];
  assign ups     = 3'(north_q) + 3'(south_q) + 3'(w_bit) + 3'(e_bit);
  assign de_up   = $signed({ups, 2'b00}) - DE_P8;
  assign de_eval = s_bit ? de_up : -de_up;

  always_comb begin
    acc_ctl.load    = (state == S_EVAL);
    acc_ctl.de      = de_eval;
    acc_ctl.spin_up = s_bit;
    acc_ctl.rnd     = rnd_q;
  end

  imf_accept u_accept (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .ctl       (acc_ctl),
    .accept    (accept)
  );

  always_comb begin
    st_ctl.clear   = in_req && op_clear;
    st_ctl.update  = (state == S_DEC) && accept;
    st_ctl.de      = de_q;
    st_ctl.spin_up = spin_q;
  end

  imf_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .ctl       (st_ctl),
    .energy    (st_energy),
    .sq_energy (st_sq),
    .mag       (st_mag)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ROW_W'(SIDE - 1)) begin
          state_next = clr_push ? S_PUSH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req) begin
          state_next = op_clear ? S_CLEAR : S_NBR;
        end
      end
      S_NBR:  state_next = S_EVAL;
      S_EVAL: state_next = S_MUL;
      S_MUL:  state_next = S_DEC;
      S_DEC:  state_next = S_PUSH;
      S_PUSH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_push   <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (in_req && op_clear) begin
        clr_addr <= '0;
        clr_push <= 1'b1;
      end else if (out_load) begin
        clr_push <= 1'b0;
      end
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      row_q <= row_in;
      col_q <= col_in;
      rnd_q <= in_tdata[IN_RND_LSB +: RND_W];
      de_q  <= '0;
      acc_q <= 1'b0;
    end
    if (state == S_NBR) begin
      north_q <= rd_data_a[col_q];
      south_q <= rd_data_b[col_q];
    end
    if (state == S_EVAL) begin
      de_q       <= de_eval;
      spin_q     <= s_bit;
      row_word_q <= rd_data_a;
    end
    if (state == S_DEC) begin
      acc_q <= accept;
    end
    if (out_load) begin
      out_tdata <= OUT_W'({st_mag, st_sq, st_energy, de_q, acc_q});
    end
  end

endmodule

@@ src/imf_checker.sv @@
`timescale 1ns / 1ps
`include "ising_metropolis_flip_defines.svh"

module imf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [imf_pkg::OUT_W-1:0] out_tdata
);

  import imf_pkg::*;

  logic [DE_W-1:0] de_f;
  logic            mag_lsb;
  logic            de_ok;

  assign de_f    = out_tdata[OUT_DE_LSB +: DE_W];
  assign mag_lsb = out_tdata[OUT_MAG_LSB];
  assign de_ok   = (de_f == '0) || (de_f == DE_P4) || (de_f == DE_P8)
                || (de_f == DE_M4) || (de_f == DE_M8);

  `IMF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `IMF_ASSERT_NXT(a_one_request, in_tvalid && in_tready, !in_tready)
  `IMF_ASSERT_IMP(a_mag_even, out_tvalid, !mag_lsb)
  `IMF_ASSERT_IMP(a_de_legal, out_tvalid, de_ok)

endmodule

bind ising_metropolis_flip imf_checker u_imf_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import imf_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam longint ENERGY_MAX = 64'sd2147483647;
  localparam longint ENERGY_MIN = -64'sd2147483648;
  localparam longint unsigned SQ_MAX = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic                    accepted;
    logic signed [DE_W-1:0]  de;
    logic signed [E_W-1:0]   energy;
    logic [SQ_W-1:0]         sq_energy;
    logic signed [MAG_W-1:0] mag;
  } flip_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_tvalid = 1'b0;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  wire                  in_tready;
  wire                  out_tvalid;
  wire [OUT_W-1:0]      out_tdata;

  bit               lattice_up [SIDE][SIDE];
  logic [CFG_W-1:0] factors [6];
  longint           energy_model;
  longint unsigned  sq_model;
  int               mag_model;
  flip_result_t     pending_results [$];
  int               error_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               cycle_count = 0;

  ising_metropolis_flip DUT (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic clear_lattice_model();
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        lattice_up[r][c] = 1'b1;
    energy_model = 0;
    sq_model = 0;
    mag_model = SITES;
  endtask

  function automatic int spin_of(input int r, input int c);
    return lattice_up[(r + SIDE) % SIDE][(c + SIDE) % SIDE] ? 1 : -1;
  endfunction

  // metropolis step on the local lattice copy, queues the expected result
  task automatic predict_flip(input logic op, input logic [ROW_W-1:0] row,
                              input logic [ROW_W-1:0] col, input logic [RND_W-1:0] rnd);
    flip_result_t          res;
    int                    r;
    int                    c;
    int                    s;
    int                    nsum;
    int                    de;
    logic signed [DE_W-1:0] de_code;
    logic [CFG_W-1:0]      fe;
    logic [CFG_W-1:0]      fs;
    longint unsigned       product;
    res.accepted = 1'b0;
    de = 0;
    if (op == OP_CLEAR) begin
      clear_lattice_model();
    end else begin
      r = int'(row) % SIDE;
      c = int'(col) % SIDE;
      s = spin_of(r, c);
      nsum = spin_of(r - 1, c) + spin_of(r + 1, c) + spin_of(r, c - 1) + spin_of(r, c + 1);
      de = 2 * s * nsum;
      de_code = DE_W'(de);
      case (de_code)
        DE_M8: fe = factors[REG_DE_M8];
        DE_M4: fe = factors[REG_DE_M4];
        DE_P4: fe = factors[REG_DE_P4];
        DE_P8: fe = factors[REG_DE_P8];
        default: fe = ONE_FACTOR;
      endcase
      fs = (s > 0) ? factors[REG_SPIN_UP] : factors[REG_SPIN_DOWN];
      product = 64'(fe) * 64'(fs);
      if ({32'b0, rnd, 16'b0} < product) begin
        res.accepted = 1'b1;
        lattice_up[r][c] = (s < 0);
        energy_model = energy_model + de;
        if (energy_model > ENERGY_MAX) energy_model = ENERGY_MAX;
        if (energy_model < ENERGY_MIN) energy_model = ENERGY_MIN;
        sq_model = sq_model + longint'(de * de);
        if (sq_model > SQ_MAX) sq_model = SQ_MAX;
        mag_model = mag_model - 2 * s;
      end
    end
    res.de = DE_W'(de);
    res.energy = E_W'(energy_model);
    res.sq_energy = SQ_W'(sq_model);
    res.mag = MAG_W'(mag_model);
    pending_results.push_back(res);
  endtask

  task automatic send_request(input logic op, input logic [ROW_W-1:0] row,
                              input logic [ROW_W-1:0] col, input logic [RND_W-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, rnd, col, row};
    do @(posedge clk); while (!in_tready);
    predict_flip(op, row, col, rnd);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_factor(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    factors[idx] = value;
  endtask

  task automatic set_factors(input logic [CFG_W-1:0] m8, input logic [CFG_W-1:0] m4,
                             input logic [CFG_W-1:0] p4, input logic [CFG_W-1:0] p8,
                             input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] down);
    write_factor(REG_DE_M8, m8);
    write_factor(REG_DE_M4, m4);
    write_factor(REG_DE_P4, p4);
    write_factor(REG_DE_P8, p8);
    write_factor(REG_SPIN_UP, up);
    write_factor(REG_SPIN_DOWN, down);
    cfg_we <= 1'b0;
  endtask

  task automatic check_result();
    flip_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing outstanding");
    end else begin
      want = pending_results.pop_front();
      compare_field("accepted", out_tdata[OUT_ACC_LSB], want.accepted);
      compare_field("delta_energy", $signed(out_tdata[OUT_DE_LSB +: DE_W]), want.de);
      compare_field("energy_sum", $signed(out_tdata[OUT_E_LSB +: E_W]), want.energy);
      compare_field("sq_energy_sum", out_tdata[OUT_SQ_LSB +: SQ_W], want.sq_energy);
      compare_field("magnetization", $signed(out_tdata[OUT_MAG_LSB +: MAG_W]), want.mag);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_tvalid && out_tready)
      check_result();
  end

  // reset factors, wrapped corners, every energy change sign, clear
  task automatic test_directed_sites();
    send_idle_pct = 16;
    recv_idle_pct = 63;
    send_request(OP_CLEAR, 6'd63, 6'd63, 16'hFFFF);
    send_request(OP_FLIP, 6'd0, 6'd0, 16'hFFFF);
    send_request(OP_FLIP, 6'd0, 6'd0, 16'h0000);
    send_request(OP_FLIP, 6'd63, 6'd63, 16'h0000);
    send_request(OP_FLIP, 6'd63, 6'd0, 16'h1234);
    send_request(OP_FLIP, 6'd0, 6'd63, 16'hABCD);
    send_request(OP_FLIP, 6'd0, 6'd0, 16'h5555);
    send_request(OP_FLIP, 6'd5, 6'd5, 16'hAAAA);
    send_request(OP_FLIP, 6'd5, 6'd6, 16'h8000);
    send_request(OP_FLIP, 6'd5, 6'd6, 16'h7FFF);
    send_request(OP_FLIP, 6'd42, 6'd21, 16'hFFFE);
    send_request(OP_CLEAR, 6'd0, 6'd0, 16'h0000);
  endtask

  // product exactly equal to the scaled random value must reject
  task automatic test_directed_threshold();
    drain();
    set_factors(ONE_FACTOR, ONE_FACTOR, ONE_FACTOR, ONE_FACTOR, 24'h008000, 24'h004000);
    send_request(OP_FLIP, 6'd20, 6'd20, 16'h8000);
    send_request(OP_FLIP, 6'd20, 6'd20, 16'h7FFF);
    send_request(OP_FLIP, 6'd20, 6'd20, 16'h4000);
    send_request(OP_FLIP, 6'd20, 6'd20, 16'h3FFF);
  endtask

  task automatic test_directed_factor_extremes();
    drain();
    set_factors('0, '0, '0, '0, '0, '0);
    send_request(OP_FLIP, 6'd30, 6'd30, 16'h0000);
    drain();
    set_factors('1, '1, '1, '1, '1, '1);
    send_request(OP_FLIP, 6'd30, 6'd30, 16'hFFFF);
    send_request(OP_FLIP, 6'd30, 6'd30, 16'hFFFF);
  endtask

  // mostly dense flips in a small window that wraps the lattice edges
  task automatic run_random_flips(input int count, input int send_pct, input int recv_pct);
    int                kind;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        row = ROW_W'($urandom_range(7) - 4);
        col = ROW_W'($urandom_range(7) - 4);
      end else begin
        row = ROW_W'($urandom_range(SIDE - 1));
        col = ROW_W'($urandom_range(SIDE - 1));
      end
      send_request((kind >= 97) ? OP_CLEAR : OP_FLIP, row, col,
                   RND_W'($urandom_range(16'hFFFF)));
    end
  endtask

  task automatic test_random_physical();
    drain();
    set_factors('1, '1, 24'h002A00, 24'h0006E0, ONE_FACTOR, ONE_FACTOR);
    run_random_flips(285, 16, 63);
  endtask

  task automatic test_random_factors();
    drain();
    set_factors(CFG_W'($urandom_range(24'h1FFFF)), CFG_W'($urandom_range(24'h1FFFF)),
                CFG_W'($urandom_range(24'h1FFFF)), CFG_W'($urandom_range(24'h1FFFF)),
                CFG_W'($urandom_range(24'h1FFFF)), CFG_W'($urandom_range(24'h1FFFF)));
    run_random_flips(285, 63, 16);
  endtask

  task automatic test_random_field_bias();
    drain();
    set_factors('1, ONE_FACTOR, 24'h008000, '0, 24'h018000, 24'h00C000);
    run_random_flips(280, 0, 0);
  endtask

  initial begin
    for (int i = 0; i < 6; i++) factors[i] = ONE_FACTOR;
    clear_lattice_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_sites();
    test_directed_threshold();
    test_directed_factor_extremes();
    test_random_physical();
    test_random_factors();
    test_random_field_bias();
    drain();
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/imf_pkg.sv
src/imf_ram.sv
src/imf_accept.sv
src/imf_stats.sv
src/ising_metropolis_flip.sv
src/imf_checker.sv
dv/tb.sv
